// ===== sv/wssim_pkg.sv =====
// ---------------------------------------------------------------------------
// wssim_pkg
// Shared constants for the windowed SSIM map: parameter defaults, register
// indexes, reset values, port widths and the fixed SSIM coefficients.
// ---------------------------------------------------------------------------
package wssim_pkg;

  // parameter defaults
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_RADIUS       = 3;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_PIXEL_BITS   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam int FW_W = 11;
  localparam int FH_W = 16;
  localparam int CC_W = 3;

  localparam logic [FW_W-1:0] RST_FRAME_WIDTH   = 11'd640;
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT  = 16'd480;
  localparam logic [CC_W-1:0] RST_CHANNEL_COUNT = 3'd3;

  // payload widths
  localparam int SAMPLE_W = 8;
  localparam int SSIM_W   = 16;
  localparam int OUT_X_W  = 10;
  localparam int OUT_Y_W  = 16;

  // ssim coefficients scaled by 1/C1: 2*1, 1, C2/C1
  localparam int K_NUM = 20000;
  localparam int K_DEN = 10000;
  localparam int K_C2  = 9;

  // 1.0 in Q2.14
  localparam int SSIM_ONE = 16384;

endpackage

// ===== sv/windowed_ssim_map_top.sv =====
// ---------------------------------------------------------------------------
// windowed_ssim_map_top
// Streaming SSIM map over a square box window, one Q2.14 value per pixel.
// ---------------------------------------------------------------------------
// Pixel pairs enter in raster order and land in a line memory of 3*RADIUS+1
// rows. A word that produces a value (the pixel RADIUS rows and RADIUS
// columns ahead, or a drain word once the frame is in) starts a sweep of a
// SIDE x SIDE window, SIDE = 2*RADIUS+1, and the input is held off until
// the value is handed over.
// The window sweep reads one position a cycle through the single read port
// of the line memory, and each channel then runs two 17-step Q.16 dividers.
// In the cycle after any register write the input is held off. The line memory
// needs no clearing: every position a window reads was written in the frame.
// ---------------------------------------------------------------------------
module windowed_ssim_map_top #(
  parameter int MAX_WIDTH    = wssim_pkg::DEF_MAX_WIDTH,
  parameter int RADIUS       = wssim_pkg::DEF_RADIUS,
  parameter int MAX_CHANNELS = wssim_pkg::DEF_MAX_CHANNELS,
  parameter int PIXEL_BITS   = wssim_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wssim_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wssim_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      ref_ch0,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      ref_ch1,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      ref_ch2,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      ref_ch3,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      cmp_ch0,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      cmp_ch1,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      cmp_ch2,
  input  logic [wssim_pkg::SAMPLE_W-1:0]      cmp_ch3,
  // output words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wssim_pkg::SSIM_W-1:0] ssim_value,
  output logic [wssim_pkg::OUT_X_W-1:0]       out_x,
  output logic [wssim_pkg::OUT_Y_W-1:0]       out_y,
  output logic                                last_of_frame
);
  import wssim_pkg::*;

  localparam int SIDE  = 2 * RADIUS + 1;
  localparam int WIN_N = SIDE * SIDE;
  localparam int SLOTS = 3 * RADIUS + 1;
  localparam int SB    = $clog2(SLOTS);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = WW + 16;
  localparam int WB    = $clog2(SIDE);
  localparam int NB    = $clog2(WIN_N + 1);
  localparam int PB    = PIXEL_BITS;
  localparam int AW    = PB + NB;
  localparam int QW    = 2 * PB + NB;
  localparam int PW    = 2 * AW;
  localparam int DW    = 2 * AW + 17;
  localparam int MW    = 2 * MAX_CHANNELS * PB;
  localparam int KB    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW    = 36;
  localparam int FB    = SW - 18;

  localparam logic [63:0] M_L   = 64'((1 << PIXEL_BITS) - 1);
  localparam logic [63:0] N_L   = 64'(WIN_N);
  localparam logic [63:0] MN2_L = M_L * M_L * N_L * N_L;
  localparam logic [63:0] D9_L  = 64'(K_C2) * N_L * (N_L - 64'd1) * M_L * M_L;
  localparam logic [DW-1:0] MN2 = DW'(MN2_L);
  localparam logic [DW-1:0] D9  = DW'(D9_L);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_P1    = 4'd3;
  localparam logic [3:0] S_P2    = 4'd4;
  localparam logic [3:0] S_P3    = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MAC   = 4'd7;
  localparam logic [3:0] S_RND   = 4'd8;
  localparam logic [3:0] S_FDIV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state;

  // configuration registers and derived frame figures
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [CC_W-1:0] channel_count;
  logic            cfg_hold;
  logic [WW-1:0]   w_eff;
  logic [15:0]     h_eff;
  logic [CC_W-1:0] c_eff;
  logic [CW-1:0]   tot;
  logic [CW-1:0]   lag;

  // frame position counters
  logic [XW-1:0] in_col;
  logic [SB-1:0] in_slot;
  logic [CW-1:0] rcv;
  logic [CW-1:0] out_count;
  logic [XW-1:0] ox;
  logic [15:0]   oy;
  logic [SB-1:0] out_slot;

  // window sweep
  logic [WB-1:0]        wx, wy;
  logic signed [XW+1:0] xx;
  logic signed [17:0]   yy;
  logic [SB-1:0]        ws;
  logic [SB:0]          ws_start;
  logic                 pos_ok;

  // line memory
  logic [MW-1:0] line_mem [SLOTS][MAX_WIDTH];
  logic [MW-1:0] wdata;
  logic [MW-1:0] rdata;
  logic          rd_valid;
  logic [SB-1:0] rd_slot;
  logic [XW-1:0] rd_x;
  logic          mem_we;

  // window sums per channel
  logic [AW-1:0] sum_a  [MAX_CHANNELS];
  logic [AW-1:0] sum_b  [MAX_CHANNELS];
  logic [QW-1:0] sum_aa [MAX_CHANNELS];
  logic [QW-1:0] sum_bb [MAX_CHANNELS];
  logic [QW-1:0] sum_ab [MAX_CHANNELS];

  // per channel arithmetic
  logic [KB-1:0]        ch;
  logic [PW-1:0]        p_ab, p_aa, p_bb, p_nxx, p_nyy, p_nxy;
  logic [DW-1:0]        num_l, den_l, den_c;
  logic [PW-1:0]        vx, vy;
  logic signed [PW:0]   cxy;
  logic signed [DW:0]   ncs_w;
  logic                 c_neg;
  logic [DW:0]          r_l, r_c, t_l, t_c;
  logic [16:0]          q_l, q_c;
  logic                 bit_l, bit_c;
  logic [4:0]           step;
  logic signed [SW-1:0] s_acc;

  // final rounding divide by the channel count
  logic [SW-1:0] mag;
  logic [FB-1:0] r_f, dsh;
  logic [15:0]   q_f, q_clamp;

  // accept handshakes
  logic in_acc, pix_ok, emit, frame_done;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !cfg_hold;
  assign in_acc    = in_valid && in_ready;
  assign pix_ok    = !func && (rcv < tot);
  assign emit      = pix_ok ? (rcv >= out_count + lag)
                            : ((rcv == tot) && (out_count < tot));
  assign mem_we    = in_acc && pix_ok;
  assign frame_done = (out_count + CW'(1)) >= tot;

  // effective register values
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height == '0) ? 16'd1 : frame_height;
    if (channel_count == '0) begin
      c_eff = CC_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      c_eff = CC_W'(MAX_CHANNELS);
    end else begin
      c_eff = channel_count;
    end
  end

  // frame size and output lag, registered
  always_ff @(posedge clk) begin
    tot <= CW'(w_eff) * CW'(h_eff);
    lag <= CW'(w_eff) * CW'(RADIUS) + CW'(RADIUS);
  end

  // pack incoming samples into a memory word
  always_comb begin
    logic [SAMPLE_W-1:0] rs [4];
    logic [SAMPLE_W-1:0] cs [4];
    rs[0] = ref_ch0; rs[1] = ref_ch1; rs[2] = ref_ch2; rs[3] = ref_ch3;
    cs[0] = cmp_ch0; cs[1] = cmp_ch1; cs[2] = cmp_ch2; cs[3] = cmp_ch3;
    wdata = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      wdata[k*PB +: PB]                  = PB'(rs[k]);
      wdata[(MAX_CHANNELS+k)*PB +: PB]   = PB'(cs[k]);
    end
  end

  // window position check and read address
  assign pos_ok  = (yy >= 0) && (yy < $signed({2'b00, h_eff})) &&
                   (xx >= 0) && (xx < $signed({(XW+2-WW)'(0), w_eff}));
  assign rd_slot = ws;
  assign rd_x    = pos_ok ? xx[XW-1:0] : '0;
  assign ws_start = {1'b0, out_slot} + (SB+1)'(SLOTS - RADIUS);

  // line memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[in_slot][in_col] <= wdata;
    end
    rdata <= line_mem[rd_slot][rd_x];
  end

  // restoring divider steps, divider inputs and the output clamp
  always_comb begin
    t_l   = (step == 5'd0) ? r_l : {r_l[DW-1:0], 1'b0};
    t_c   = (step == 5'd0) ? r_c : {r_c[DW-1:0], 1'b0};
    bit_l = t_l >= {1'b0, den_l};
    bit_c = t_c >= {1'b0, den_c};
    ncs_w = (DW+1)'(cxy) * $signed((DW+1)'(K_NUM)) + $signed({1'b0, D9});
    mag   = s_acc[SW-1] ? SW'(-s_acc) : SW'(s_acc);
    dsh   = FB'(c_eff) << step[3:0];
    q_clamp = (32'(q_f) > SSIM_ONE) ? 16'(SSIM_ONE) : q_f;
  end

  // window sums
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        sum_a[k]  <= '0;
        sum_b[k]  <= '0;
        sum_aa[k] <= '0;
        sum_bb[k] <= '0;
        sum_ab[k] <= '0;
      end
    end else if (rd_valid) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        sum_a[k]  <= sum_a[k] + AW'(rdata[k*PB +: PB]);
        sum_b[k]  <= sum_b[k] + AW'(rdata[(MAX_CHANNELS+k)*PB +: PB]);
        sum_aa[k] <= sum_aa[k] + QW'(rdata[k*PB +: PB]) * QW'(rdata[k*PB +: PB]);
        sum_bb[k] <= sum_bb[k] + QW'(rdata[(MAX_CHANNELS+k)*PB +: PB])
                                * QW'(rdata[(MAX_CHANNELS+k)*PB +: PB]);
        sum_ab[k] <= sum_ab[k] + QW'(rdata[k*PB +: PB])
                                * QW'(rdata[(MAX_CHANNELS+k)*PB +: PB]);
      end
    end
  end

  // per channel datapath
  always_ff @(posedge clk) begin
    case (state)
      S_P1: begin
        p_ab  <= PW'(sum_a[ch]) * PW'(sum_b[ch]);
        p_aa  <= PW'(sum_a[ch]) * PW'(sum_a[ch]);
        p_bb  <= PW'(sum_b[ch]) * PW'(sum_b[ch]);
        p_nxx <= PW'(sum_aa[ch]) * PW'(WIN_N);
        p_nyy <= PW'(sum_bb[ch]) * PW'(WIN_N);
        p_nxy <= PW'(sum_ab[ch]) * PW'(WIN_N);
      end
      S_P2: begin
        num_l <= DW'(p_ab) * DW'(K_NUM) + MN2;
        den_l <= (DW'(p_aa) + DW'(p_bb)) * DW'(K_DEN) + MN2;
        vx    <= p_nxx - p_aa;
        vy    <= p_nyy - p_bb;
        cxy   <= $signed({1'b0, p_nxy}) - $signed({1'b0, p_ab});
      end
      S_P3: begin
        den_c <= (DW'(vx) + DW'(vy)) * DW'(K_DEN) + D9;
        c_neg <= ncs_w[DW];
        r_c   <= ncs_w[DW] ? (DW+1)'(-ncs_w) : (DW+1)'(ncs_w);
        r_l   <= {1'b0, num_l};
        q_l   <= '0;
        q_c   <= '0;
      end
      S_DIV: begin
        r_l <= bit_l ? t_l - {1'b0, den_l} : t_l;
        r_c <= bit_c ? t_c - {1'b0, den_c} : t_c;
        q_l <= {q_l[15:0], bit_l};
        q_c <= {q_c[15:0], bit_c};
      end
      S_RND: begin
        r_f <= FB'((mag + (SW'(c_eff) << 17)) >> 18);
        q_f <= '0;
      end
      S_FDIV: begin
        r_f <= (r_f >= dsh) ? r_f - dsh : r_f;
        q_f <= {q_f[14:0], r_f >= dsh};
      end
      default: begin
      end
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      channel_count <= RST_CHANNEL_COUNT;
      cfg_hold      <= 1'b1;
      in_col        <= '0;
      in_slot       <= '0;
      rcv           <= '0;
      out_count     <= '0;
      ox            <= '0;
      oy            <= '0;
      out_slot      <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
      step          <= '0;
      ch            <= '0;
    end else begin
      cfg_hold <= 1'b0;
      rd_valid <= (state == S_SWEEP) && pos_ok;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // register write restarts the frame
      if (cfg_valid && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
                        cfg_index == CFG_CHANNEL_COUNT)) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width   <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height  <= cfg_data[FH_W-1:0];
          default:          channel_count <= cfg_data[CC_W-1:0];
        endcase
        cfg_hold  <= 1'b1;
        in_col    <= '0;
        in_slot   <= '0;
        rcv       <= '0;
        out_count <= '0;
        ox        <= '0;
        oy        <= '0;
        out_slot  <= '0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (pix_ok) begin
              rcv <= rcv + CW'(1);
              if (WW'(in_col) + WW'(1) >= w_eff) begin
                in_col  <= '0;
                in_slot <= (in_slot == SB'(SLOTS - 1)) ? '0 : in_slot + SB'(1);
              end else begin
                in_col <= in_col + XW'(1);
              end
            end
            if (emit) begin
              state <= S_SWEEP;
              wx    <= '0;
              wy    <= '0;
              xx    <= $signed({2'b00, ox}) - (XW+2)'(RADIUS);
              yy    <= $signed({2'b00, oy}) - 18'(RADIUS);
              ws    <= (ws_start >= (SB+1)'(SLOTS)) ? SB'(ws_start - (SB+1)'(SLOTS))
                                                     : SB'(ws_start);
              s_acc <= '0;
              ch    <= '0;
            end
          end
        end
        // one window position per cycle
        S_SWEEP: begin
          if (wx == WB'(SIDE - 1)) begin
            wx <= '0;
            xx <= $signed({2'b00, ox}) - (XW+2)'(RADIUS);
            wy <= wy + WB'(1);
            yy <= yy + 18'sd1;
            ws <= (ws == SB'(SLOTS - 1)) ? '0 : ws + SB'(1);
            if (wy == WB'(SIDE - 1)) begin
              state <= S_DRAIN;
            end
          end else begin
            wx <= wx + WB'(1);
            xx <= xx + (XW+2)'(1);
          end
        end
        S_DRAIN: state <= S_P1;
        S_P1:    state <= S_P2;
        S_P2:    state <= S_P3;
        S_P3: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == 5'd16) begin
            state <= S_MAC;
          end
          step <= step + 5'd1;
        end
        // accumulate the channel product
        S_MAC: begin
          s_acc <= c_neg ? s_acc - SW'(q_l) * SW'(q_c) : s_acc + SW'(q_l) * SW'(q_c);
          if (CC_W'(ch) + CC_W'(1) >= c_eff) begin
            state <= S_RND;
          end else begin
            ch    <= ch + KB'(1);
            state <= S_P1;
          end
        end
        S_RND: begin
          state <= S_FDIV;
          step  <= 5'd15;
        end
        S_FDIV: begin
          if (step == 5'd0) begin
            state <= S_OUT;
          end else begin
            step <= step - 5'd1;
          end
        end
        // hand the value over and advance the output position
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            ssim_value    <= s_acc[SW-1] ? -$signed(q_clamp) : $signed(q_clamp);
            out_x         <= OUT_X_W'(ox);
            out_y         <= oy;
            last_of_frame <= (out_count + CW'(1)) == tot;
            state         <= S_IDLE;
            if (frame_done) begin
              in_col    <= '0;
              in_slot   <= '0;
              rcv       <= '0;
              out_count <= '0;
              ox        <= '0;
              oy        <= '0;
              out_slot  <= '0;
            end else begin
              out_count <= out_count + CW'(1);
              if (WW'(ox) + WW'(1) >= w_eff) begin
                ox       <= '0;
                oy       <= oy + 16'd1;
                out_slot <= (out_slot == SB'(SLOTS - 1)) ? '0 : out_slot + SB'(1);
              end else begin
                ox <= ox + XW'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_IDLE)
    else $error("line memory written outside idle");

  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    !cfg_hold |-> out_count < tot)
    else $error("output count beyond frame");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ssim_value <= 16'sd16384) && (ssim_value >= -16'sd16384))
    else $error("ssim value out of range");

  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |=> state == S_SWEEP || state == S_DRAIN)
    else $error("window sweep left early");

  a_no_read_late: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == S_SWEEP)
    else $error("window read outside sweep");

endmodule
